@@ rtl/core/arpc_pkg.sv @@
package arpc_pkg;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        OC_MISS     = 4'd0,
        OC_HIT      = 4'd1,
        OC_IGNORED  = 4'd2,
        OC_REFRESH  = 4'd3,
        OC_CHANGED  = 4'd4,
        OC_FILLED   = 4'd5,
        OC_EVICTED  = 4'd6,
        OC_TICK     = 4'd7,
        OC_AGING    = 4'd8
    } outcome_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    localparam logic [0:0] REG_TICK_DIVIDE = 1'b0;
    localparam logic [0:0] REG_AGE_LIMIT   = 1'b1;

    localparam logic [15:0] TICK_DIVIDE_RESET = 16'd50;
    localparam logic [7:0]  AGE_LIMIT_RESET   = 8'd60;

    // One classified command as it travels from the front to the back.
    typedef struct packed {
        cmd_t        cmd;
        logic        ignore;
        logic        pass;
        logic [2:0]  iface;
        logic [31:0] ip_addr;
        logic [47:0] mac_in;
    } job_t;

endpackage

@@ rtl/core/arp_cache_with_aging.sv @@
// ARP cache with aging. Commands enter on the in channel (lookup, add, timer
// tick) and each gives exactly one result transaction on the out channel.
// A front end classifies each command (zero top byte on add, whether a tick
// completes the divider) and places it in a two-entry queue; a back end then
// walks the table one entry per cycle. The back end takes one item at a time,
// from the idle state through scan, write and done, and a lookup or add that
// hits ends the scan early. The write step waits while an earlier result is
// still stalled at the output. Configuration writes take effect at once
// and are meant for idle periods only.
module arp_cache_with_aging #(
    parameter int ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [2:0]  iface,
    input  logic [31:0] ip_addr,
    input  logic [47:0] mac_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  outcome,
    output logic [47:0] mac_out,
    output logic [4:0]  expired_count,
    output logic [31:0] change_stamp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import arpc_pkg::*;

    logic [15:0] tick_divide_reg;
    logic [7:0]  age_limit_reg;
    logic        q_valid, q_take;
    job_t        q_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_divide_reg <= TICK_DIVIDE_RESET;
            age_limit_reg   <= AGE_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TICK_DIVIDE: tick_divide_reg <= cfg_data;
                REG_AGE_LIMIT:   age_limit_reg   <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    arpc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid       (in_valid),
        .stall       (in_stall),
        .command     (command),
        .iface       (iface),
        .ip_addr     (ip_addr),
        .mac_in      (mac_in),
        .tick_divide (tick_divide_reg),
        .q_valid     (q_valid),
        .q_take      (q_take),
        .q_job       (q_job)
    );

    arpc_back #(.ENTRIES(ENTRIES)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_take        (q_take),
        .q_job         (q_job),
        .age_limit     (age_limit_reg),
        .valid         (out_valid),
        .stall         (out_stall),
        .outcome       (outcome),
        .mac_out       (mac_out),
        .expired_count (expired_count),
        .change_stamp  (change_stamp)
    );
endmodule

@@ rtl/core/arpc_front.sv @@
module arpc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              stall,
    input  logic [1:0]        command,
    input  logic [2:0]        iface,
    input  logic [31:0]       ip_addr,
    input  logic [47:0]       mac_in,
    input  logic [15:0]       tick_divide,
    output logic              q_valid,
    input  logic              q_take,
    output arpc_pkg::job_t    q_job
);
    import arpc_pkg::*;

    // Two-entry queue toward the back end.
    job_t        q_mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic [15:0] tick_count_reg;
    logic        push;
    logic [15:0] tick_inc;
    job_t        job;

    assign stall   = (cnt_reg == 2'd2);
    assign push    = valid && !stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_job   = q_mem_reg[rd_ptr_reg];
    assign tick_inc = tick_count_reg + 16'd1;

    always_comb
    begin
        job.cmd     = cmd_t'(command);
        job.ignore  = (ip_addr[31:24] == 8'd0);
        job.pass    = (tick_inc >= tick_divide);
        job.iface   = iface;
        job.ip_addr = ip_addr;
        job.mac_in  = mac_in;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            cnt_reg        <= 2'd0;
            tick_count_reg <= 16'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_take)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_take};
            if (push && job.cmd == CMD_TICK)
            begin
                tick_count_reg <= job.pass ? 16'd0 : tick_inc;
            end
        end
    end
endmodule

@@ rtl/core/arpc_back.sv @@
module arpc_back #(
    parameter int ENTRIES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_take,
    input  arpc_pkg::job_t    q_job,
    input  logic [7:0]        age_limit,
    output logic              valid,
    input  logic              stall,
    output logic [3:0]        outcome,
    output logic [47:0]       mac_out,
    output logic [4:0]        expired_count,
    output logic [31:0]       change_stamp
);
    import arpc_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    state_t state_reg, state_next;

    logic [ENTRIES-1:0] valid_reg;
    logic [7:0]         age_reg [ENTRIES];
    logic [2:0]         ifc_reg [ENTRIES];
    logic [31:0]        ip_reg  [ENTRIES];
    logic [47:0]        mac_reg [ENTRIES];

    job_t        job_reg;
    logic [CW-1:0] idx_reg;
    logic        found_reg, free_reg;
    logic [IW-1:0] match_reg, free_idx_reg, old_reg;
    logic [7:0]  old_age_reg;
    logic [4:0]  exp_reg;
    logic [31:0] stamp_reg;

    logic        out_v_reg;
    logic [3:0]  out_oc_reg;
    logic [47:0] out_mac_reg;
    logic [4:0]  out_exp_reg;

    logic [IW-1:0] i;
    logic          last;
    logic          hit_l, hit_a;
    logic [7:0]    aged;
    logic [IW-1:0] tgt;
    logic          differ;
    logic          out_free;

    assign i      = idx_reg[IW-1:0];
    assign last   = (idx_reg == CW'(ENTRIES - 1));
    assign hit_l  = valid_reg[i] && ifc_reg[i] == job_reg.iface && ip_reg[i] == job_reg.ip_addr;
    assign hit_a  = valid_reg[i] && ip_reg[i] == job_reg.ip_addr;
    assign aged   = (age_reg[i] == 8'hFF) ? 8'hFF : age_reg[i] + 8'd1;
    assign tgt    = found_reg ? match_reg : (free_reg ? free_idx_reg : old_reg);
    assign differ = mac_reg[tgt] != job_reg.mac_in || ifc_reg[tgt] != job_reg.iface;

    // The write step may only proceed once the output register is free.
    assign out_free = !out_v_reg || !stall;

    assign q_take        = (state_reg == ST_IDLE) && q_valid;
    assign valid         = out_v_reg;
    assign outcome       = out_oc_reg;
    assign mac_out       = out_mac_reg;
    assign expired_count = out_exp_reg;
    assign change_stamp  = stamp_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last || (job_reg.cmd == CMD_LOOKUP && hit_l)
                    || (job_reg.cmd == CMD_ADD && hit_a))
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_v_reg || !stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid)
        begin
            job_reg      <= q_job;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            free_reg     <= 1'b0;
            match_reg    <= '0;
            free_idx_reg <= '0;
            old_reg      <= '0;
            old_age_reg  <= 8'd0;
            exp_reg      <= 5'd0;
        end
        else if (state_reg == ST_SCAN)
        begin
            idx_reg <= idx_reg + CW'(1);
            if (job_reg.cmd == CMD_LOOKUP && hit_l)
            begin
                found_reg   <= 1'b1;
                match_reg   <= i;
            end
            if (job_reg.cmd == CMD_ADD)
            begin
                if (hit_a)
                begin
                    found_reg <= 1'b1;
                    match_reg <= i;
                end
                if (!valid_reg[i] && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= i;
                end
                if (idx_reg == '0 || age_reg[i] > old_age_reg)
                begin
                    old_reg     <= i;
                    old_age_reg <= age_reg[i];
                end
            end
            if (job_reg.cmd == CMD_TICK && job_reg.pass && valid_reg[i]
                && aged > age_limit && exp_reg != 5'd31)
            begin
                exp_reg <= exp_reg + 5'd1;
            end
        end
    end

    // Table storage: entries are updated during the scan (aging) or in the write step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int k = 0; k < ENTRIES; k++)
            begin
                age_reg[k] <= 8'd0;
            end
        end
        else if (state_reg == ST_SCAN && job_reg.cmd == CMD_TICK && job_reg.pass
                 && valid_reg[i])
        begin
            age_reg[i] <= aged;
            if (aged > age_limit)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (state_reg == ST_WRITE && out_free)
        begin
            if (job_reg.cmd == CMD_LOOKUP && found_reg)
            begin
                age_reg[match_reg] <= 8'd0;
            end
            if (job_reg.cmd == CMD_ADD && !job_reg.ignore)
            begin
                age_reg[tgt]   <= 8'd0;
                valid_reg[tgt] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE && out_free && job_reg.cmd == CMD_ADD && !job_reg.ignore)
        begin
            ip_reg[tgt]  <= job_reg.ip_addr;
            mac_reg[tgt] <= job_reg.mac_in;
            ifc_reg[tgt] <= job_reg.iface;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_reg <= 32'd0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (out_v_reg && !stall)
            begin
                out_v_reg <= 1'b0;
            end
            if (state_reg == ST_WRITE && out_free)
            begin
                if (job_reg.cmd == CMD_ADD && !job_reg.ignore
                    && (!found_reg || differ))
                begin
                    stamp_reg <= stamp_reg + 32'd1;
                end
            end
            if (state_reg == ST_DONE && (!out_v_reg || !stall))
            begin
                out_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE && out_free)
        begin
            out_mac_reg <= 48'd0;
            out_exp_reg <= 5'd0;
            unique case (job_reg.cmd)
                CMD_LOOKUP:
                begin
                    out_oc_reg <= found_reg ? OC_HIT : OC_MISS;
                    if (found_reg)
                    begin
                        out_mac_reg <= mac_reg[match_reg];
                    end
                end
                CMD_ADD:
                begin
                    if (job_reg.ignore)
                        out_oc_reg <= OC_IGNORED;
                    else if (found_reg)
                        out_oc_reg <= differ ? OC_CHANGED : OC_REFRESH;
                    else
                        out_oc_reg <= free_reg ? OC_FILLED : OC_EVICTED;
                end
                CMD_TICK:
                begin
                    out_oc_reg  <= job_reg.pass ? OC_AGING : OC_TICK;
                    out_exp_reg <= exp_reg;
                end
                default:
                begin
                    out_oc_reg <= OC_MISS;
                end
            endcase
        end
    end
endmodule

@@ rtl/core/arpc_checker.sv @@
module arpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [3:0]  outcome,
    input logic [47:0] mac_out,
    input logic [4:0]  expired_count
);
    import arpc_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(outcome))
        else $error("result changed while stalled");

    a_mac: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && outcome != OC_HIT |-> mac_out == 48'd0)
        else $error("mac on non-hit");

    a_exp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && outcome != OC_AGING |-> expired_count == 5'd0)
        else $error("expired count outside aging pass");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> outcome <= OC_AGING)
        else $error("bad outcome");
endmodule

bind arp_cache_with_aging arpc_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .outcome       (outcome),
    .mac_out       (mac_out),
    .expired_count (expired_count)
);
